### design/mmnb_pkg.sv
// shared types, constants and helpers for the min-max byte normalizer
package mmnb_pkg;

	// sample and datapath widths
	localparam int SampleBits = 16;
	localparam int ValW       = 17;            // decoded sample, running extremes
	localparam int DiffW      = ValW + 1;      // range and offset, exact
	localparam int PixW       = 8;
	localparam int NumW       = ValW + PixW;   // offset times 255
	localparam int CntW       = $clog2(PixW);

	// item commands
	typedef enum logic [1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_SCAN    = 2'd1,
		CMD_CONVERT = 2'd2
	} mmnb_cmd_t;

	// sample formats
	typedef enum logic [1:0] {
		FMT_U8  = 2'd0,
		FMT_U16 = 2'd1,
		FMT_S16 = 2'd2
	} mmnb_fmt_t;

	// register indexes
	localparam logic REG_SAMPLE_FORMAT = 1'b0;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_OUT
	} mmnb_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic clear;
		logic scan;
		logic capture;
		logic setup;
		logic div_step;
		logic out_load;
	} mmnb_ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic need_div;
		logic div_last;
	} mmnb_stat_t;

	localparam logic signed [ValW-1:0] MinReset = ValW'(65535);
	localparam logic signed [ValW-1:0] MaxReset = -ValW'(32768);

	// decode raw sample bits to a signed value per format
	function automatic logic signed [ValW-1:0] decode_sample(
		input logic [1:0]  fmt,
		input logic [15:0] raw
	);
		logic [SampleBits-1:0] bits;
		logic signed [ValW-1:0] val;
		bits = raw[SampleBits-1:0];
		case (fmt)
			FMT_U8:  val = ValW'(raw[7:0]);
			FMT_S16: val = ValW'($signed(bits));
			default: val = ValW'(bits);
		endcase
		return val;
	endfunction

endpackage

### design/mmnb_ctrl.sv
// controller state machine: handshakes, sequencing of setup, divide and result load
module mmnb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic [1:0]        cmd,
	output logic              item_ready,
	output logic              result_valid,
	input  logic              result_ready,
	input  mmnb_pkg::mmnb_stat_t stat,
	output mmnb_pkg::mmnb_ctl_t  ctl
);
	import mmnb_pkg::*;

	mmnb_state_t state_q, state_d;
	logic        out_valid_q;

	assign result_valid = out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		ctl        = '0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					case (cmd)
						CMD_CLEAR: ctl.clear = 1'b1;
						CMD_SCAN:  ctl.scan  = 1'b1;
						CMD_CONVERT: begin
							ctl.capture = 1'b1;
							state_d     = ST_SETUP;
						end
						default: ;
					endcase
				end
			end
			ST_SETUP: begin
				ctl.setup = 1'b1;
				state_d   = stat.need_div ? ST_DIV : ST_OUT;
			end
			ST_DIV: begin
				ctl.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || result_ready) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// output register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

### design/mmnb_datapath.sv
// datapath: running extremes, range and offset, restoring divider, result register
module mmnb_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        sample_format,
	input  logic [15:0]       sample,
	input  mmnb_pkg::mmnb_ctl_t  ctl,
	output mmnb_pkg::mmnb_stat_t stat,
	output logic [7:0]        pixel,
	output logic              flat_range
);
	import mmnb_pkg::*;

	logic signed [ValW-1:0]  min_q, max_q, s_val;
	logic signed [DiffW-1:0] range_s1, diff_s1;
	logic                    pass_s1;
	logic [PixW-1:0]         byte_s1;
	logic                    is_flat, is_zero, is_sat;
	logic [NumW-1:0]         rem_q, den_q, num;
	logic [PixW-1:0]         quo_q;
	logic                    flat_q;
	logic [CntW-1:0]         cnt_q;
	logic                    ge;
	logic [ValW-1:0]         diff_mag, range_mag;
	logic [PixW-1:0]         pixel_q;
	logic                    flat_out_q;

	assign s_val = decode_sample(sample_format, sample);

	// running extremes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MinReset;
			max_q <= MaxReset;
		end else if (ctl.clear) begin
			min_q <= MinReset;
			max_q <= MaxReset;
		end else if (ctl.scan) begin
			if (s_val < min_q) begin
				min_q <= s_val;
			end
			if (s_val > max_q) begin
				max_q <= s_val;
			end
		end
	end

	// capture range and offset of a convert transaction
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			range_s1 <= DiffW'(max_q) - DiffW'(min_q);
			diff_s1  <= DiffW'(s_val) - DiffW'(min_q);
			pass_s1  <= (sample_format == FMT_U8);
			byte_s1  <= sample[PixW-1:0];
		end
	end

	// special cases and divider operands
	assign is_flat   = (range_s1 <= 0);
	assign is_zero   = (diff_s1 <= 0);
	assign is_sat    = (diff_s1 >= range_s1);
	assign diff_mag  = diff_s1[ValW-1:0];
	assign range_mag = range_s1[ValW-1:0];
	assign num       = {diff_mag, {PixW{1'b0}}} - NumW'(diff_mag);
	assign ge        = (rem_q >= den_q);

	assign stat.need_div = !pass_s1 && !is_flat && !is_zero && !is_sat;
	assign stat.div_last = (cnt_q == '0);

	// divider iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.setup) begin
			cnt_q <= CntW'(PixW - 1);
		end else if (ctl.div_step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// restoring divider, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (ctl.setup) begin
			rem_q  <= num;
			den_q  <= NumW'({range_mag, {(PixW-1){1'b0}}});
			flat_q <= !pass_s1 && is_flat;
			if (pass_s1) begin
				quo_q <= byte_s1;
			end else if (is_flat || is_zero) begin
				quo_q <= '0;
			end else if (is_sat) begin
				quo_q <= '1;
			end else begin
				quo_q <= '0;
			end
		end else if (ctl.div_step) begin
			if (ge) begin
				rem_q <= rem_q - den_q;
			end
			den_q <= den_q >> 1;
			quo_q <= {quo_q[PixW-2:0], ge};
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			pixel_q    <= quo_q;
			flat_out_q <= flat_q;
		end
	end

	assign pixel      = pixel_q;
	assign flat_range = flat_out_q;

endmodule

### design/minmax_normalize_to_byte_core.sv
// Min-max contrast stretch of a sample stream to 8 bits (top level).
//
// Item channel (item_valid/item_ready, cmd, sample): clear resets the running
// extremes, scan widens them to cover the sample, convert yields one result.
// Result channel (result_valid/result_ready, pixel, flat_range): one transaction
// per convert, pixel = floor((sample - min) * 255 / (max - min)), saturated;
// flat_range is set with pixel 0 when max - min is zero or below, except in
// passthrough. sample_format sits at address 0 of the APB port: 0 8-bit
// passthrough, 1 unsigned 16-bit, 2 signed 16-bit.
// A convert runs capture, setup and load when the result is passthrough,
// flat, zero or saturated, else capture, setup, 8 steps of the restoring
// divider (one quotient bit a cycle) and load.
// The result register frees the divider: a new transaction is taken while a
// result waits; a second convert holds in its load state until the receiver
// takes the first. Reset clears the format to passthrough, sets min to 65535
// and max to -32768, and empties the result register.
module minmax_normalize_to_byte_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// item channel
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  cmd,
	input  logic [15:0] sample,
	// result channel
	output logic        result_valid,
	input  logic        result_ready,
	output logic [7:0]  pixel,
	output logic        flat_range
);
	import mmnb_pkg::*;

	logic [1:0] fmt_q;
	mmnb_ctl_t  ctl;
	mmnb_stat_t stat;

	assign pready = 1'b1;

	// format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_U8;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_SAMPLE_FORMAT) begin
			fmt_q <= pwdata[1:0];
		end
	end

	// register read
	assign prdata = (paddr[2] == REG_SAMPLE_FORMAT) ? {30'd0, fmt_q} : 32'd0;

	mmnb_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.cmd          (cmd),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.stat         (stat),
		.ctl          (ctl)
	);

	mmnb_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_format (fmt_q),
		.sample        (sample),
		.ctl           (ctl),
		.stat          (stat),
		.pixel         (pixel),
		.flat_range    (flat_range)
	);

`ifndef SYNTHESIS
	// a flat range always reports pixel zero
	a_flat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && flat_range |-> pixel == '0)
		else $error("flat range with nonzero pixel");

	// a convert transaction blocks the item channel for the next cycle
	a_conv_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && cmd == CMD_CONVERT |=> !item_ready)
		else $error("item accepted during convert");

	// the divider never steps while items are taken
	a_div_excl: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.div_step |-> !item_ready)
		else $error("divide step while item channel open");
`endif

endmodule
